/* hdl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes, reset values and helper functions of the session
// timer serial slave.
// ----------------------------------------------------------------------------
package sts_pkg;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // session status codes
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_WORKING = 2'd1;
  localparam logic [1:0] ST_COOLING = 2'd2;
  localparam logic [1:0] ST_WAITING = 2'd3;

  // command codes in bits 2..0 of an addressed command byte
  localparam logic [2:0] CMD_STATUS   = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_ARM_PRE  = 3'd2;
  localparam logic [2:0] CMD_ARM_COOL = 3'd3;
  localparam logic [2:0] CMD_ARM_MAIN = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_MINUTE_LIMIT = 2'd1;
  localparam logic [1:0] REG_LINK_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_START_DELAY  = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values
  localparam logic [3:0]  RST_NODE_ADDRESS = 4'd14;
  localparam logic [15:0] RST_MINUTE_LIMIT = 16'd60000;
  localparam logic [15:0] RST_LINK_TIMEOUT = 16'd1500;
  localparam logic [15:0] RST_START_DELAY  = 16'd2000;
  localparam logic [15:0] RST_LINK_TIMER   = 16'd1000;

  localparam logic [6:0] CHECKSUM_BIAS = 7'd5;

  typedef enum logic [4:0] {
    PH_NONE  = 5'b00001,
    PH_PRE   = 5'b00010,
    PH_MAIN  = 5'b00100,
    PH_COOL  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] session_status;
    logic [7:0] remaining_minutes;
    logic       relay_main;
    logic       relay_fan;
  } result_t;

  // binary to three bcd digits, tens by reciprocal multiply
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  ones_w;
    logic [1:0]  hund;
    logic [4:0]  tens_w;
    prod   = 16'(v) * 16'd205;
    q      = prod[15:11];
    ones_w = v - 8'(q) * 8'd10;
    if (q >= 5'd20) begin
      hund = 2'd2;
    end else if (q >= 5'd10) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    tens_w = q - 5'(hund) * 5'd10;
    return {2'b00, hund, tens_w[3:0], ones_w[3:0]};
  endfunction

  function automatic logic [1:0] session_status(input logic [7:0] pre,
                                                input logic [7:0] main,
                                                input logic [7:0] cool);
    logic [1:0] s;
    if (pre != 8'd0) begin
      s = ST_WAITING;
    end else if (main != 8'd0) begin
      s = ST_WORKING;
    end else if (cool != 8'd0) begin
      s = ST_COOLING;
    end else begin
      s = ST_FREE;
    end
    return s;
  endfunction

  function automatic logic [7:0] session_minutes(input logic [7:0] pre,
                                                 input logic [7:0] main,
                                                 input logic [7:0] cool);
    logic [7:0] m;
    if (pre != 8'd0) begin
      m = pre;
    end else if (main != 8'd0) begin
      m = main;
    end else begin
      m = cool;
    end
    return m;
  endfunction

endpackage

/* hdl/sts_in_stage.sv */
// ----------------------------------------------------------------------------
// sts_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module sts_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sts_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output sts_pkg::item_t item
);

  logic           valid_r;
  sts_pkg::item_t item_r;
  logic           take;

  assign in_stall   = valid_r && !advance;
  assign take       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

/* hdl/sts_core.sv */
// ----------------------------------------------------------------------------
// sts_core
// Session state, configuration registers and the per-item update logic.
// ----------------------------------------------------------------------------
module sts_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sts_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 fire,
  input  sts_pkg::item_t                       item,
  output sts_pkg::result_t                     result
);

  logic [3:0]  addr_r;
  logic [15:0] limit_r, lto_r, delay_r;

  logic [7:0]  pre_r, main_r, cool_r, pre_nxt, main_nxt, cool_nxt;
  logic [7:0]  ppre_r, pmain_r, pcool_r, ppre_nxt, pmain_nxt, pcool_nxt;
  sts_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] link_r, link_nxt, ms_r, ms_nxt, hold_r, hold_nxt;

  logic [7:0]  d;
  logic [1:0]  st_now, st_nxt;
  logic [7:0]  min_now, min_nxt;
  logic [11:0] bcd_now;
  logic [6:0]  ck_regs, ck_cool;
  logic [11:0] bcd_pmain;
  logic        upd, tx;
  logic [7:0]  txb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= sts_pkg::RST_NODE_ADDRESS;
      limit_r <= sts_pkg::RST_MINUTE_LIMIT;
      lto_r   <= sts_pkg::RST_LINK_TIMEOUT;
      delay_r <= sts_pkg::RST_START_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sts_pkg::REG_NODE_ADDRESS: addr_r  <= cfg_data[3:0];
        sts_pkg::REG_MINUTE_LIMIT: limit_r <= cfg_data;
        sts_pkg::REG_LINK_TIMEOUT: lto_r   <= cfg_data;
        sts_pkg::REG_START_DELAY:  delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign d         = item.rx_byte;
  assign st_now    = sts_pkg::session_status(pre_r, main_r, cool_r);
  assign min_now   = sts_pkg::session_minutes(pre_r, main_r, cool_r);
  assign bcd_now   = sts_pkg::to_bcd(min_now);
  assign bcd_pmain = sts_pkg::to_bcd(pmain_r);
  assign ck_regs   = ppre_r[6:0] + pcool_r[6:0] - bcd_pmain[6:0] - sts_pkg::CHECKSUM_BIAS;
  assign ck_cool   = ppre_r[6:0] + d[6:0] - bcd_pmain[6:0] - sts_pkg::CHECKSUM_BIAS;

  always_comb begin
    pre_nxt   = pre_r;
    main_nxt  = main_r;
    cool_nxt  = cool_r;
    ppre_nxt  = ppre_r;
    pmain_nxt = pmain_r;
    pcool_nxt = pcool_r;
    phase_nxt = phase_r;
    link_nxt  = link_r;
    ms_nxt    = ms_r;
    hold_nxt  = hold_r;
    upd       = 1'b0;
    tx        = 1'b0;
    txb       = 8'd0;
    if (fire) begin
      if (item.operation == sts_pkg::OP_BYTE) begin
        if (d[7]) begin
          if (d[6:3] == addr_r) begin
            link_nxt = lto_r;
            unique case (d[2:0])
              sts_pkg::CMD_STATUS: begin
                tx  = 1'b1;
                txb = {st_now, 6'd0} | bcd_now[7:0];
              end
              sts_pkg::CMD_START: begin
                pre_nxt  = 8'd0;
                hold_nxt = delay_r;
                upd      = 1'b1;
              end
              sts_pkg::CMD_ARM_PRE:  phase_nxt = sts_pkg::PH_PRE;
              sts_pkg::CMD_ARM_MAIN: phase_nxt = sts_pkg::PH_MAIN;
              sts_pkg::CMD_ARM_COOL: phase_nxt = sts_pkg::PH_COOL;
              default: ;
            endcase
          end
        end else begin
          unique case (phase_r)
            sts_pkg::PH_PRE: begin
              ppre_nxt  = d;
              phase_nxt = sts_pkg::PH_NONE;
            end
            sts_pkg::PH_MAIN: begin
              pmain_nxt = 8'(d[7:4]) * 8'd10 + 8'(d[3:0]);
              phase_nxt = sts_pkg::PH_NONE;
            end
            sts_pkg::PH_COOL: begin
              pcool_nxt = d;
              phase_nxt = sts_pkg::PH_CHECK;
              tx        = 1'b1;
              txb       = {1'b0, ck_cool};
            end
            sts_pkg::PH_CHECK: begin
              if (d == {1'b0, ck_regs}) begin
                pre_nxt  = ppre_r;
                main_nxt = pmain_r;
                cool_nxt = pcool_r;
                if (ppre_r == 8'd0 && pmain_r != 8'd0) begin
                  hold_nxt = delay_r;
                end
                upd    = 1'b1;
                ms_nxt = 16'd0;
              end
              phase_nxt = sts_pkg::PH_NONE;
            end
            default: ;
          endcase
        end
      end else begin
        if (hold_r != 16'd0) begin
          hold_nxt = hold_r - 16'd1;
        end
        if (ms_r > limit_r) begin
          ms_nxt = 16'd0;
          if (pre_r != 8'd0) begin
            pre_nxt = pre_r - 8'd1;
            if (pre_r == 8'd1 && main_r != 8'd0) begin
              hold_nxt = delay_r;
            end
          end else if (main_r != 8'd0) begin
            main_nxt = main_r - 8'd1;
          end else if (cool_r != 8'd0) begin
            cool_nxt = cool_r - 8'd1;
          end
        end else begin
          ms_nxt = ms_r + 16'd1;
        end
        if (link_r != 16'd0) begin
          link_nxt = link_r - 16'd1;
          if (link_r == 16'd1) begin
            phase_nxt = sts_pkg::PH_NONE;
            ppre_nxt  = 8'd0;
            pmain_nxt = 8'd0;
            pcool_nxt = 8'd0;
          end
        end
        upd = 1'b1;
      end
    end
    st_nxt  = sts_pkg::session_status(pre_nxt, main_nxt, cool_nxt);
    min_nxt = sts_pkg::session_minutes(pre_nxt, main_nxt, cool_nxt);
    if (upd && (st_nxt == sts_pkg::ST_COOLING || st_nxt == sts_pkg::ST_FREE)) begin
      hold_nxt = 16'd0;
    end
  end

  always_comb begin
    result.tx_valid          = tx;
    result.tx_byte           = txb;
    result.session_status    = st_nxt;
    result.remaining_minutes = min_nxt;
    result.relay_main        = (st_nxt == sts_pkg::ST_WORKING);
    result.relay_fan         = (st_nxt == sts_pkg::ST_WORKING ||
                                st_nxt == sts_pkg::ST_COOLING) && (hold_nxt == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r   <= 8'd0;
      main_r  <= 8'd0;
      cool_r  <= 8'd0;
      ppre_r  <= 8'd0;
      pmain_r <= 8'd0;
      pcool_r <= 8'd0;
      phase_r <= sts_pkg::PH_NONE;
      link_r  <= sts_pkg::RST_LINK_TIMER;
      ms_r    <= 16'd0;
      hold_r  <= 16'd0;
    end else begin
      pre_r   <= pre_nxt;
      main_r  <= main_nxt;
      cool_r  <= cool_nxt;
      ppre_r  <= ppre_nxt;
      pmain_r <= pmain_nxt;
      pcool_r <= pcool_nxt;
      phase_r <= phase_nxt;
      link_r  <= link_nxt;
      ms_r    <= ms_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

/* hdl/sts_out_stage.sv */
// ----------------------------------------------------------------------------
// sts_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module sts_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sts_pkg::result_t result,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output sts_pkg::result_t out_result
);

  logic             valid_r;
  sts_pkg::result_t result_r;

  assign room       = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

/* hdl/session_timer_serial_slave.sv */
// ----------------------------------------------------------------------------
// session_timer_serial_slave
// Addressed serial slave running a pre/main/cool session timer.
//
// The input channel (in_valid/in_stall) takes one item per cycle while
// in_stall is low: a received byte or a millisecond tick. Each item yields
// exactly one result item on the output channel (out_valid/out_stall)
// carrying the optional reply byte, the session status, the remaining
// minutes and the two relay states. An accepted item sits in the input
// register and passes the update logic into the result register, where
// out_valid shows it until the receiver takes it.
// The state update keeps pace with one item per cycle while out_stall is low.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; after that in_stall rises until the result is taken.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per handshake.
// Synchronous reset loads the default address, limits and an idle session,
// and empties both registers.
// ----------------------------------------------------------------------------
module session_timer_serial_slave (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic [1:0]  out_session_status,
  output logic [7:0]  out_remaining_minutes,
  output logic        out_relay_main,
  output logic        out_relay_fan
);

  sts_pkg::item_t   in_item, item;
  sts_pkg::result_t result, out_result;
  logic             item_valid, room, advance;

  assign cfg_ready = 1'b1;

  assign in_item.operation = in_operation;
  assign in_item.rx_byte   = in_rx_byte;
  assign advance           = item_valid && room;

  sts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  sts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_tx_valid          = out_result.tx_valid;
  assign out_tx_byte           = out_result.tx_byte;
  assign out_session_status    = out_result.session_status;
  assign out_remaining_minutes = out_result.remaining_minutes;
  assign out_relay_main        = out_result.relay_main;
  assign out_relay_fan         = out_result.relay_fan;

endmodule
